// ===== hdl/scna_pkg.sv =====
// Package for the sorted center nearest assignment block.
// Types, constants and field structs; no dependencies.
package scna_pkg;
    localparam int MAX_CENTERS = 16;
    localparam int MAX_DIMS    = 8;
    localparam int COORD_BITS  = 16;
    localparam int CI_W   = $clog2(MAX_CENTERS);
    localparam int DI_W   = $clog2(MAX_DIMS);
    localparam int CC_AW  = CI_W + DI_W;
    localparam int ROW_AW = 2 * CI_W;
    localparam int DIST_W = 37;
    localparam int ROW_W  = 38;
    localparam int CFG_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_BUILD = 2'd1;
    localparam logic [1:0] FUNC_POINT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CENTERS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = 1'd1;

    typedef struct packed {
        logic [1:0]            func;
        logic [3:0]            center_index;
        logic [2:0]            dim_index;
        logic signed [15:0]    coord;
        logic [3:0]            current_assignment;
        logic                  last_coord;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        closest_center;
        logic [DIST_W-1:0] min_distance;
        logic              changed;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_B_ROWINIT, ST_B_DRD, ST_B_DACC, ST_B_DWR,
        ST_B_INS_RD, ST_B_INS_CHK, ST_B_INS_SH, ST_B_INS_PUT,
        ST_P_DRD, ST_P_DACC, ST_P_DDONE,
        ST_P_ROWRD, ST_P_ROWCHK,
        ST_OUT
    } state_t;
endpackage

// ===== hdl/scna_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
// No package dependency.
module scna_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/sorted_center_nearest_assign.sv =====
// Top level: sorted center nearest assignment.
// Uses scna_pkg and scna_ram (center coordinates, sorted row table).
//
// channel | dir | handshake            | payload
// s_      | in  | s_valid / s_ready    | s_data (in_item_t)
// m_      | out | m_valid / m_ready    | m_data (out_item_t)
// cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// Load and plain point coordinates are taken in IDLE. Build: per row, the
// distance to each center, then an insertion sort of the row with key reads,
// neighbor shifts and a put. Last point coordinate: a distance per row entry
// visited, each followed by a row entry read and check. One item at a time.
// Reset is synchronous, active low, clears control only. A stalled result
// holds in the output register; no new item is accepted until it leaves.
module sorted_center_nearest_assign (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  scna_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output scna_pkg::out_item_t             m_data,
    input  logic                            cfg_we,
    input  logic [scna_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scna_pkg::CFG_W-1:0]      cfg_data
);
    import scna_pkg::*;

    state_t state_reg, state_next;
    logic [4:0] nc_reg;
    logic [3:0] nd_reg;

    // center coordinate memory
    logic              cc_we;
    logic [CC_AW-1:0]  cc_waddr, cc_raddr;
    logic [15:0]       cc_wdata, cc_rdata;
    // row memory: {center, distance}
    logic              rw_we;
    logic [ROW_AW-1:0] rw_waddr, rw_raddr;
    logic [ROW_W+3:0]  rw_wdata, rw_rdata;

    scna_ram #(.WIDTH(16), .DEPTH(MAX_CENTERS*MAX_DIMS)) u_cc (
        .aclk, .we(cc_we), .waddr(cc_waddr), .wdata(cc_wdata),
        .raddr(cc_raddr), .rdata(cc_rdata));
    scna_ram #(.WIDTH(ROW_W+4), .DEPTH(MAX_CENTERS*MAX_CENTERS)) u_row (
        .aclk, .we(rw_we), .waddr(rw_waddr), .wdata(rw_wdata),
        .raddr(rw_raddr), .rdata(rw_rdata));

    logic signed [15:0] pbuf_reg [MAX_DIMS];

    logic [CI_W:0]   k_eff;
    logic [DI_W:0]   d_eff;
    always_comb begin
        k_eff = (nc_reg < 5'd2) ? 5'd2 : (nc_reg > 5'(MAX_CENTERS)) ? 5'(MAX_CENTERS) : nc_reg;
        d_eff = (nd_reg < 4'd1) ? 4'd1 : (nd_reg > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : nd_reg;
    end

    // distance engine: two operand sources, term reads alternating
    logic [CI_W-1:0] ca_reg, cb_reg;       // centers a (or point) and b
    logic            usept_reg;            // operand a is the point
    logic [DI_W:0]   t_reg;
    logic            ph_reg;               // 0: read a, 1: read b
    logic signed [15:0] opa_reg;
    logic [ROW_W-1:0] acc_reg;
    logic signed [16:0] diff_w;
    logic [33:0]     sq_w;

    // build / search control
    logic [CI_W:0]   j_reg, p_reg, q_reg;
    logic [ROW_W-1:0] kd_reg;
    logic [CI_W-1:0] kc_reg;
    logic [CI_W-1:0] best_reg;
    logic [ROW_W-1:0] bd_reg;
    logic [CI_W:0]   o_reg;
    logic [3:0]      cur_reg;
    out_item_t       out_reg;
    logic            mv_reg;
    logic            first_reg;
    logic            search_stop;
    logic            ins_shift;
    logic            start_ok;

    assign diff_w = 17'(opa_reg) - 17'(signed'(cc_rdata));
    assign sq_w   = unsigned'(34'(diff_w) * 34'(diff_w));

    logic accept;
    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    assign start_ok = ({1'b0, s_data.current_assignment} < k_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nc_reg <= 5'd2;
            nd_reg <= 4'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_NUM_CENTERS: nc_reg <= cfg_data;
                REG_NUM_DIMS:    nd_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            if (state_reg == ST_OUT) mv_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept && s_data.func == FUNC_POINT) begin
            pbuf_reg[s_data.dim_index] <= s_data.coord;
            cur_reg <= s_data.current_assignment;
        end
        case (state_reg)
            ST_IDLE: begin
                t_reg <= '0; ph_reg <= 1'b0; acc_reg <= '0;
                j_reg <= '0; p_reg <= '0;
                if (accept && s_data.func == FUNC_POINT) begin
                    usept_reg <= 1'b1;
                    ca_reg    <= '0;
                    cb_reg    <= start_ok ? s_data.current_assignment[CI_W-1:0] : '0;
                    best_reg  <= start_ok ? s_data.current_assignment[CI_W-1:0] : '0;
                    o_reg     <= 5'd1;
                end else begin
                    usept_reg <= 1'b0;
                end
            end
            ST_B_ROWINIT: begin
                ca_reg <= j_reg[CI_W-1:0];
                cb_reg <= p_reg[CI_W-1:0];
                t_reg <= '0; ph_reg <= 1'b0; acc_reg <= '0;
            end
            ST_B_DRD, ST_P_DRD: ph_reg <= 1'b0;
            ST_B_DACC, ST_P_DACC: begin
                if (!ph_reg) begin
                    opa_reg <= usept_reg ? pbuf_reg[t_reg[DI_W-1:0]] : signed'(cc_rdata);
                    ph_reg  <= 1'b1;
                end else begin
                    acc_reg <= acc_reg + ROW_W'(sq_w);
                    t_reg   <= t_reg + 1'b1;
                    ph_reg  <= 1'b0;
                end
            end
            ST_B_DWR: begin
                t_reg <= '0; acc_reg <= '0;
                if (p_reg + 1'b1 == k_eff) begin
                    p_reg <= 5'd1;
                end else begin
                    p_reg <= p_reg + 1'b1;
                end
            end
            ST_B_INS_RD: begin
                kd_reg <= '0;
            end
            ST_B_INS_CHK: begin
                if (q_reg == p_reg) begin
                    kd_reg <= rw_rdata[ROW_W-1:0];
                    kc_reg <= rw_rdata[ROW_W+CI_W-1:ROW_W];
                end
            end
            ST_B_INS_SH: if (ins_shift) q_reg <= q_reg - 1'b1;
            ST_B_INS_PUT: begin
                if (p_reg + 1'b1 == k_eff) begin
                    j_reg <= j_reg + 1'b1;
                    p_reg <= '0;
                end else begin
                    p_reg <= p_reg + 1'b1;
                end
            end
            ST_P_DDONE: begin
                t_reg <= '0; acc_reg <= '0;
            end
            default: ;
        endcase
        if (state_reg == ST_B_DWR) q_reg <= 5'd1;
        if (state_reg == ST_B_INS_PUT && p_reg + 1'b1 != k_eff) q_reg <= p_reg + 1'b1;
        // search bookkeeping
        if (state_reg == ST_P_ROWCHK && !search_stop) begin
            cb_reg <= rw_rdata[ROW_W+CI_W-1:ROW_W];
        end
        if (state_reg == ST_P_DDONE && first_reg == 1'b0) begin
            if (acc_reg < bd_reg || (acc_reg == bd_reg && cb_reg < best_reg)) begin
                bd_reg   <= acc_reg;
                best_reg <= cb_reg;
                o_reg    <= 5'd1;
            end else begin
                o_reg <= o_reg + 1'b1;
            end
        end
        if (state_reg == ST_P_DDONE && first_reg) bd_reg <= acc_reg;
        if (state_reg == ST_OUT) begin
            out_reg.closest_center <= 4'(best_reg);
            out_reg.min_distance   <= bd_reg[DIST_W-1:0];
            out_reg.changed        <= (4'(best_reg) != cur_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) first_reg <= 1'b1;
        else if (state_reg == ST_P_DDONE) first_reg <= 1'b0;
    end

    assign search_stop = ({bd_reg, 2'b00} < {2'b00, rw_rdata[ROW_W-1:0]});

    assign ins_shift = (q_reg != 0) && (rw_rdata[ROW_W-1:0] > kd_reg ||
                       (rw_rdata[ROW_W-1:0] == kd_reg &&
                        rw_rdata[ROW_W+CI_W-1:ROW_W] > kc_reg));

    // memory ports and next state
    always_comb begin
        state_next = state_reg;
        cc_we = 1'b0;
        cc_waddr = {s_data.center_index[CI_W-1:0], s_data.dim_index[DI_W-1:0]};
        cc_wdata = s_data.coord;
        // build: a[t] is read before its term, b[t] while a[t] is latched
        if (state_reg == ST_B_DACC) begin
            cc_raddr = ph_reg ? {ca_reg, DI_W'(t_reg + 1'b1)} : {cb_reg, t_reg[DI_W-1:0]};
        end else begin
            cc_raddr = {ca_reg, t_reg[DI_W-1:0]};
        end
        if (usept_reg) cc_raddr = {cb_reg, t_reg[DI_W-1:0]};
        rw_we = 1'b0;
        rw_waddr = {j_reg[CI_W-1:0], p_reg[CI_W-1:0]};
        rw_wdata = {4'(p_reg), acc_reg};
        rw_raddr = {j_reg[CI_W-1:0], q_reg[CI_W-1:0]};
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.func == FUNC_LOAD) cc_we = 1'b1;
                    else if (s_data.func == FUNC_BUILD) state_next = ST_B_ROWINIT;
                    else if (s_data.func == FUNC_POINT && s_data.last_coord)
                        state_next = ST_P_DRD;
                end
            end
            ST_B_ROWINIT: state_next = ST_B_DRD;
            ST_B_DRD: state_next = ST_B_DACC;
            ST_B_DACC: begin
                if (ph_reg && t_reg + 1'b1 == d_eff) state_next = ST_B_DWR;
                else state_next = ST_B_DACC;
            end
            ST_B_DWR: begin
                rw_we = 1'b1;
                if (p_reg == j_reg) rw_wdata = {4'(p_reg), {ROW_W{1'b0}}};
                if (p_reg + 1'b1 == k_eff) state_next = ST_B_INS_RD;
                else state_next = ST_B_ROWINIT;
            end
            ST_B_INS_RD: state_next = ST_B_INS_CHK;
            ST_B_INS_CHK: begin
                if (q_reg == p_reg) begin
                    // key loaded; read the left neighbor
                    rw_raddr = {j_reg[CI_W-1:0], CI_W'(q_reg - 1'b1)};
                    state_next = ST_B_INS_SH;
                end else begin
                    state_next = ST_B_INS_SH;
                end
            end
            ST_B_INS_SH: begin
                if (ins_shift) begin
                    rw_we = 1'b1;
                    rw_waddr = {j_reg[CI_W-1:0], q_reg[CI_W-1:0]};
                    rw_wdata = rw_rdata;
                    rw_raddr = {j_reg[CI_W-1:0], CI_W'(q_reg - 2'd2)};
                    state_next = (q_reg == 5'd1) ? ST_B_INS_PUT : ST_B_INS_SH;
                end else begin
                    state_next = ST_B_INS_PUT;
                end
            end
            ST_B_INS_PUT: begin
                rw_we = 1'b1;
                rw_waddr = {j_reg[CI_W-1:0],
                            (state_reg == ST_B_INS_PUT) ? CI_W'(q_reg) : CI_W'(q_reg)};
                rw_wdata = {4'(kc_reg), kd_reg};
                if (p_reg + 1'b1 == k_eff) begin
                    state_next = (j_reg + 1'b1 == k_eff) ? ST_IDLE : ST_B_ROWINIT;
                end else begin
                    state_next = ST_B_INS_RD;
                end
            end
            ST_P_DRD: state_next = ST_P_DACC;
            ST_P_DACC: begin
                if (ph_reg && t_reg + 1'b1 == d_eff) state_next = ST_P_DDONE;
                else state_next = ST_P_DACC;
            end
            ST_P_DDONE: state_next = ST_P_ROWRD;
            ST_P_ROWRD: begin
                rw_raddr = {best_reg, o_reg[CI_W-1:0]};
                state_next = (o_reg >= k_eff) ? ST_OUT : ST_P_ROWCHK;
            end
            ST_P_ROWCHK: state_next = search_stop ? ST_OUT : ST_P_DRD;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input accepted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> m_valid)
        else $error("result lost");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("result changed while stalled");
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for sorted_center_nearest_assign: randomized center loads, table
// builds and point searches, checked against an in-bench nearest-center predictor.
// Depends on scna_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
    import scna_pkg::*;

    localparam int SETTLE_CYCLES = 8000;
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    always #5 aclk = ~aclk;

    sorted_center_nearest_assign dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic signed [15:0] ctr_coord [MAX_CENTERS][MAX_DIMS];
    longint unsigned row_dist [MAX_CENTERS][MAX_CENTERS];
    int row_ctr [MAX_CENTERS][MAX_CENTERS];
    logic signed [15:0] pt_buf [MAX_DIMS];
    int k_reg = 2;
    int d_reg = 1;

    in_item_t pending_items[$];
    out_item_t expected_assign[$];
    int errors = 0;
    int n_points = 0;
    int n_builds = 0;
    int n_cfg = 0;
    int n_checked = 0;
    bit sender_hold = 1'b0;
    bit no_idle = 1'b0;
    bit stall_req = 1'b0;
    bit stall_done = 1'b0;
    int gap_cnt = 0;
    int hold_cnt = 0;
    longint cycles = 0;

    function automatic int eff_k();
        return (k_reg < 2) ? 2 : (k_reg > MAX_CENTERS) ? MAX_CENTERS : k_reg;
    endfunction

    function automatic int eff_d();
        return (d_reg < 1) ? 1 : (d_reg > MAX_DIMS) ? MAX_DIMS : d_reg;
    endfunction

    function automatic longint unsigned sq_dist(logic signed [15:0] a, logic signed [15:0] b);
        longint df;
        df = longint'(a) - longint'(b);
        return longint'(df * df);
    endfunction

    function automatic longint unsigned center_gap(int a, int b, int nd);
        longint unsigned s;
        s = 0;
        for (int t = 0; t < nd; t++) s += sq_dist(ctr_coord[a][t], ctr_coord[b][t]);
        return s;
    endfunction

    function automatic longint unsigned point_gap(int c, int nd);
        longint unsigned s;
        s = 0;
        for (int t = 0; t < nd; t++) s += sq_dist(pt_buf[t], ctr_coord[c][t]);
        return s;
    endfunction

    function automatic void rebuild_center_table();
        int k, nd, q, kc;
        longint unsigned kd;
        k = eff_k();
        nd = eff_d();
        for (int j = 0; j < k; j++) begin
            for (int p = 0; p < k; p++) begin
                row_dist[j][p] = (p == j) ? 0 : (center_gap(j, p, nd) & ((64'd1 << 38) - 1));
                row_ctr[j][p] = p;
            end
            for (int p = 1; p < k; p++) begin
                kd = row_dist[j][p];
                kc = row_ctr[j][p];
                q = p;
                while (q > 0 && (row_dist[j][q-1] > kd ||
                       (row_dist[j][q-1] == kd && row_ctr[j][q-1] > kc))) begin
                    row_dist[j][q] = row_dist[j][q-1];
                    row_ctr[j][q] = row_ctr[j][q-1];
                    q--;
                end
                row_dist[j][q] = kd;
                row_ctr[j][q] = kc;
            end
        end
    endfunction

    function automatic out_item_t nearest_center_search(int cur);
        int k, nd, best, o, j;
        longint unsigned bd, d;
        out_item_t r;
        k = eff_k();
        nd = eff_d();
        best = (cur < k) ? cur : 0;
        bd = point_gap(best, nd);
        o = 1;
        while (o < k) begin
            if ((bd << 2) < row_dist[best][o]) break;
            j = row_ctr[best][o] % MAX_CENTERS;
            d = point_gap(j, nd);
            if (d < bd || (d == bd && j < best)) begin
                bd = d;
                best = j;
                o = 1;
            end else begin
                o++;
            end
        end
        r.closest_center = best[3:0];
        r.min_distance = bd[DIST_W-1:0];
        r.changed = (best != cur);
        return r;
    endfunction

    function automatic void predict_item(in_item_t it);
        case (it.func)
            FUNC_LOAD: ctr_coord[it.center_index][it.dim_index] = it.coord;
            FUNC_BUILD: begin
                rebuild_center_table();
                n_builds++;
            end
            FUNC_POINT: begin
                pt_buf[it.dim_index] = it.coord;
                if (it.last_coord) begin
                    expected_assign.push_back(nearest_center_search(int'(it.current_assignment)));
                    n_points++;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 9) < 7) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) predict_item(s_data);
            if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                s_valid <= 1'b0;
            end else if (!sender_hold && pending_items.size() > 0) begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
                gap_cnt <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t exp_r;
        cycles <= cycles + 1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_assign.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %p", $time, m_data);
                    errors++;
                end else begin
                    exp_r = expected_assign.pop_front();
                    n_checked++;
                    if (m_data.closest_center !== exp_r.closest_center) begin
                        $display("%0t: closest_center expected %0d actual %0d", $time,
                                 exp_r.closest_center, m_data.closest_center);
                        errors++;
                    end
                    if (m_data.min_distance !== exp_r.min_distance) begin
                        $display("%0t: min_distance expected %0d actual %0d", $time,
                                 exp_r.min_distance, m_data.min_distance);
                        errors++;
                    end
                    if (m_data.changed !== exp_r.changed) begin
                        $display("%0t: changed expected %0d actual %0d", $time,
                                 exp_r.changed, m_data.changed);
                        errors++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready <= 1'b0;
            end else if (stall_req && !stall_done) begin
                stall_done <= 1'b1;
                hold_cnt <= 600;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 9) < 7) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                hold_cnt <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                       : $urandom_range(10, 50);
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic in_item_t mk(logic [1:0] f, int ci, int di, int c, int cur, bit last);
        in_item_t it;
        it.func = f;
        it.center_index = ci[3:0];
        it.dim_index = di[2:0];
        it.coord = c[15:0];
        it.current_assignment = cur[3:0];
        it.last_coord = last;
        return it;
    endfunction

    task automatic wait_idle();
        wait (pending_items.size() == 0 && !s_valid && expected_assign.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_NUM_CENTERS) k_reg = val & 5'h1f;
        else d_reg = val & 4'hf;
        n_cfg++;
    endtask

    task automatic push_point(int c, int cur, bit rnd_order);
        int nd, base;
        int dims[$];
        nd = eff_d();
        for (int t = 0; t < nd; t++) dims.push_back(t);
        if (rnd_order) dims.shuffle();
        for (int t = 0; t < nd; t++) begin
            if (c < 0) base = $urandom_range(0, 65535) - 32768;
            else base = int'(ctr_coord[c][dims[t]]) + $urandom_range(0, 600) - 300;
            if (base > 32767) base = 32767;
            if (base < -32768) base = -32768;
            pending_items.push_back(mk(FUNC_POINT, $urandom_range(0, 15), dims[t], base,
                                       (t == nd - 1) ? cur : $urandom_range(0, 15),
                                       t == nd - 1));
        end
    endtask

    task automatic push_random(int n_items);
        int cnt, r, k;
        cnt = 0;
        k = eff_k();
        while (cnt < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                push_point(($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, k - 1),
                           ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, k - 1),
                           $urandom_range(0, 1));
                cnt += eff_d();
            end else if (r < 85) begin
                pending_items.push_back(mk(FUNC_LOAD, $urandom_range(0, 15),
                    $urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 15),
                    $urandom_range(0, 1)));
                cnt++;
            end else if (r < 87) begin
                pending_items.push_back(mk(FUNC_BUILD, $urandom_range(0, 15),
                    $urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 15),
                    $urandom_range(0, 1)));
                cnt++;
            end else if (r < 92) begin
                pending_items.push_back(mk(2'd3, $urandom_range(0, 15), $urandom_range(0, 7),
                    $urandom_range(0, 65535), $urandom_range(0, 15), $urandom_range(0, 1)));
            end else begin
                pending_items.push_back(mk(FUNC_POINT, $urandom_range(0, 15),
                    $urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 15), 0));
                cnt++;
            end
        end
    endtask

    int phase_k[10] = '{2, 0, 31, 5, 16, 9, 3, 16, 1, 12};
    int phase_d[10] = '{1, 3, 15, 0, 8, 4, 2, 8, 16, 6};

    initial begin
        for (int t = 0; t < MAX_DIMS; t++) pt_buf[t] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        write_reg(REG_NUM_CENTERS, 16);
        write_reg(REG_NUM_DIMS, 8);

        // every center coordinate gets a value before any search reads it
        for (int c = 0; c < MAX_CENTERS; c++)
            for (int t = 0; t < MAX_DIMS; t++)
                pending_items.push_back(mk(FUNC_LOAD, c, t,
                    (c == 5) ? (3 * 100 + t) : (c * 1000 - 8000 + t * 37), 0, c == 1));
        pending_items.push_back(mk(FUNC_LOAD, 0, 0, 32767, 0, 0));
        pending_items.push_back(mk(FUNC_LOAD, 15, 0, -32768, 0, 0));
        pending_items.push_back(mk(FUNC_BUILD, 0, 0, 0, 0, 1));
        for (int t = 0; t < MAX_DIMS; t++)
            pending_items.push_back(mk(FUNC_POINT, 0, t, 0, 15, t == MAX_DIMS - 1));
        for (int t = 0; t < MAX_DIMS; t++)
            pending_items.push_back(mk(FUNC_POINT, 0, t, 32767, 0, t == MAX_DIMS - 1));
        for (int t = 0; t < MAX_DIMS; t++)
            pending_items.push_back(mk(FUNC_POINT, 0, t, -32768, 15, t == MAX_DIMS - 1));
        pending_items.push_back(mk(2'd3, 15, 7, -1, 15, 1));
        pending_items.push_back(mk(FUNC_POINT, 0, 3, 1000, 7, 1));

        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            write_reg(REG_NUM_CENTERS, phase_k[ph]);
            write_reg(REG_NUM_DIMS, phase_d[ph]);
            no_idle = (ph == 4 || ph == 7);
            if (ph != 6) pending_items.push_back(mk(FUNC_BUILD, 0, 0, 0, 0, 0));
            if (ph == 2) stall_req = 1'b1;
            push_random(38);
            if (ph == 5) begin
                wait (pending_items.size() == 0 && !s_valid);
                sender_hold = 1'b1;
                wait (expected_assign.size() == 0);
                sender_hold = 1'b0;
            end
            push_random(38);
        end

        wait_idle();
        $display("Covered %0d searches checked, %0d table builds, %0d register writes,",
                 n_checked, n_builds, n_cfg);
        $display("with saturated settings, stale tables and back-pressure stalls.");
        if (errors == 0 && expected_assign.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_assign.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== sorted_center_nearest_assign.f =====
hdl/scna_pkg.sv
hdl/scna_ram.sv
hdl/sorted_center_nearest_assign.sv
bench/tb_top.sv
